### rtl/stereo_comb_allpass_reverb_core_macros.svh
// Assertion macros shared by the reverb core.
`ifndef STEREO_COMB_ALLPASS_REVERB_CORE_MACROS_SVH
`define STEREO_COMB_ALLPASS_REVERB_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRV_ASSERT_HOLDS(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRV_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/crv_pkg.sv
// ----------------------------------------------------------------------------
// crv_pkg
// Shared types, constants and the delay tuning table of the reverb core.
// ----------------------------------------------------------------------------
`default_nettype none

package crv_pkg;

  // Default sizes.
  localparam int DEF_DELAY_WORDS       = 65536;
  localparam int DEF_NUM_COMB_LINES    = 8;
  localparam int DEF_NUM_ALLPASS_LINES = 4;
  localparam int DEF_SAMPLE_BITS       = 24;

  // Coefficient operand of the shared multiplier: 17-bit magnitude plus sign.
  localparam int COEF_W = 18;
  localparam int LEN_W  = 16;

  // Fixed input gain of 0.015 in Q0.16 and the right-side length offset.
  localparam logic [COEF_W-1:0] INPUT_GAIN = 18'd983;
  localparam int SPREAD = 23;

  localparam logic [10:0] COMB_TUNE [8] = '{
    11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617
  };
  localparam logic [10:0] AP_TUNE [4] = '{11'd556, 11'd441, 11'd341, 11'd225};

  // Operation presented to the shared multiply-accumulate unit.
  typedef struct packed {
    logic valid;
    logic clear;
  } mac_op_t;

  // Commands to the line table.
  typedef struct packed {
    logic init;
    logic adv;
  } line_cmd_t;

  // Tuning at unit rate scale for line k; comb pairs first, then allpass pairs.
  function automatic logic [10:0] line_tuning(input logic [5:0] k,
                                              input logic [5:0] comb_lines2);
    logic [5:0]  j;
    logic [10:0] t;
    j = k - comb_lines2;
    if (k < comb_lines2) begin
      t = COMB_TUNE[k[3:1]];
    end else begin
      t = AP_TUNE[j[2:1]];
    end
    return t + (k[0] ? 11'(SPREAD) : 11'd0);
  endfunction

endpackage

`default_nettype wire

### rtl/crv_mac.sv
// ----------------------------------------------------------------------------
// crv_mac
// Shared multiply-accumulate unit: one registered product stage followed by
// an accumulator, so the sum reflects an operation once it has passed both.
// ----------------------------------------------------------------------------
`default_nettype none

module crv_mac #(
  parameter int A_W   = 29,
  parameter int ACC_W = 49
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire crv_pkg::mac_op_t              op,
  input  wire logic signed [A_W-1:0]         a,
  input  wire logic signed [crv_pkg::COEF_W-1:0] b,
  output logic signed [ACC_W-1:0]            acc
);

  localparam int P_W = A_W + crv_pkg::COEF_W;

  logic signed [P_W-1:0] prod;
  logic                  pend_valid;
  logic                  pend_clear;

  // Control of the product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_clear <= 1'b0;
    end else begin
      pend_valid <= op.valid;
      pend_clear <= op.clear;
    end
  end

  // Product register and accumulator.
  always_ff @(posedge clk) begin
    prod <= a * b;
    if (pend_valid) begin
      acc <= (pend_clear ? '0 : acc) + ACC_W'(prod);
    end
  end

endmodule

`default_nettype wire

### rtl/crv_dmem.sv
// ----------------------------------------------------------------------------
// crv_dmem
// Delay sample store: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crv_dmem #(
  parameter int DELAY_WORDS = crv_pkg::DEF_DELAY_WORDS,
  parameter int SAMPLE_BITS = crv_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [$clog2(DELAY_WORDS)-1:0]       waddr,
  input  wire logic signed [SAMPLE_BITS-1:0]        wdata,
  input  wire logic [$clog2(DELAY_WORDS)-1:0]       raddr,
  output logic signed [SAMPLE_BITS-1:0]             rdata
);

  logic signed [SAMPLE_BITS-1:0] mem [DELAY_WORDS];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/crv_lines.sv
// ----------------------------------------------------------------------------
// crv_lines
// Per-line length, base, position and current store address. The address is
// kept alongside the position so that no base-plus-position add is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module crv_lines #(
  parameter int DELAY_WORDS = crv_pkg::DEF_DELAY_WORDS,
  parameter int NUM_LINES   = 24
) (
  input  wire logic                                clk,
  input  wire crv_pkg::line_cmd_t                  cmd,
  input  wire logic [$clog2(NUM_LINES)-1:0]        idx,
  input  wire logic [crv_pkg::LEN_W-1:0]           init_len,
  input  wire logic [$clog2(DELAY_WORDS)-1:0]      init_base,
  output logic [$clog2(DELAY_WORDS)-1:0]           cur_addr
);

  localparam int AW  = $clog2(DELAY_WORDS);
  localparam int LW  = crv_pkg::LEN_W;

  logic [LW-1:0] len  [NUM_LINES];
  logic [AW-1:0] base [NUM_LINES];
  logic [LW-1:0] pos  [NUM_LINES];
  logic [AW-1:0] addr [NUM_LINES];

  logic [LW:0]   pos_inc;
  logic [AW:0]   addr_inc;

  assign cur_addr = addr[idx];
  assign pos_inc  = {1'b0, pos[idx]} + 1'b1;
  assign addr_inc = {1'b0, addr[idx]} + 1'b1;

  // Set up a line on a length pass, or step it after an access.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      len[idx]  <= init_len;
      base[idx] <= init_base;
      pos[idx]  <= '0;
      addr[idx] <= init_base;
    end else if (cmd.adv) begin
      if (pos_inc >= {1'b0, len[idx]}) begin
        pos[idx]  <= '0;
        addr[idx] <= base[idx];
      end else begin
        pos[idx]  <= pos_inc[LW-1:0];
        addr[idx] <= (addr_inc == (AW+1)'(DELAY_WORDS)) ? '0 : addr_inc[AW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/stereo_comb_allpass_reverb_core.sv
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb_core
// Mono-in, stereo-out reverb of damped comb lines and series allpass lines,
// run by a sequencer around one multiply-accumulate unit and one delay store.
// ----------------------------------------------------------------------------
// Each accepted sample passes through the input gain, then each comb line in
// turn (its read, three products through the shared multiplier and its
// write), then each allpass line (a read and a write of the delay store), and
// then the output mix. The sequencer returns to idle before the next sample
// can be taken, so the core does not take a new sample before it is through
// with the last one. in_stall stays high while a sample is in work. After
// reset the store is cleared one word a cycle, then line lengths are set up;
// a write of the rate scale register runs the same length pass before the
// next sample is taken. A finished result waits in the output register while
// the next sample is accepted.
`default_nettype none

`include "stereo_comb_allpass_reverb_core_macros.svh"

module stereo_comb_allpass_reverb_core #(
  parameter int DELAY_WORDS       = crv_pkg::DEF_DELAY_WORDS,
  parameter int NUM_COMB_LINES    = crv_pkg::DEF_NUM_COMB_LINES,
  parameter int NUM_ALLPASS_LINES = crv_pkg::DEF_NUM_ALLPASS_LINES,
  parameter int SAMPLE_BITS       = crv_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_left,
  output logic signed [SAMPLE_BITS-1:0]      out_right,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [16:0]                   cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int NC    = NUM_COMB_LINES;
  localparam int TL    = 2 * (NUM_COMB_LINES + NUM_ALLPASS_LINES);
  localparam int LIW   = $clog2(TL);
  localparam int LPN   = 2 * NUM_COMB_LINES;
  localparam int LPW   = $clog2(LPN);
  localparam int AW    = $clog2(DELAY_WORDS);
  localparam int CW    = SB + 5;
  localparam int CF    = crv_pkg::COEF_W;
  localparam int ACC_W = CW + CF + 2;
  localparam int LW    = crv_pkg::LEN_W;

  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(32768);
  localparam logic [AW+1:0]           DWV  = (AW+2)'(DELAY_WORDS);

  // Register indexes.
  localparam logic [2:0] REG_ROOM = 3'd0;
  localparam logic [2:0] REG_DAMP = 3'd1;
  localparam logic [2:0] REG_WETD = 3'd2;
  localparam logic [2:0] REG_WETC = 3'd3;
  localparam logic [2:0] REG_DRY  = 3'd4;
  localparam logic [2:0] REG_RATE = 3'd5;

  // Sequencer states.
  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_LEN_MUL = 5'd1;
  localparam logic [4:0] S_LEN_W1  = 5'd2;
  localparam logic [4:0] S_LEN_SET = 5'd3;
  localparam logic [4:0] S_IDLE    = 5'd4;
  localparam logic [4:0] S_IN_MUL  = 5'd5;
  localparam logic [4:0] S_IN_W1   = 5'd6;
  localparam logic [4:0] S_IN_SET  = 5'd7;
  localparam logic [4:0] S_C_RD    = 5'd8;
  localparam logic [4:0] S_C_M1    = 5'd9;
  localparam logic [4:0] S_C_M2    = 5'd10;
  localparam logic [4:0] S_C_W1    = 5'd11;
  localparam logic [4:0] S_C_F     = 5'd12;
  localparam logic [4:0] S_C_M3    = 5'd13;
  localparam logic [4:0] S_C_W2    = 5'd14;
  localparam logic [4:0] S_C_WR    = 5'd15;
  localparam logic [4:0] S_A_RD    = 5'd16;
  localparam logic [4:0] S_A_WR    = 5'd17;
  localparam logic [4:0] S_O_M1    = 5'd18;
  localparam logic [4:0] S_O_M2    = 5'd19;
  localparam logic [4:0] S_O_M3    = 5'd20;
  localparam logic [4:0] S_O_M4    = 5'd21;
  localparam logic [4:0] S_O_M5    = 5'd22;
  localparam logic [4:0] S_O_M6    = 5'd23;
  localparam logic [4:0] S_O_W1    = 5'd24;
  localparam logic [4:0] S_OUT     = 5'd25;

  // Round half up at bit 16.
  function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
    return (v + HALF) >>> 16;
  endfunction

  // Saturate to a signed sample.
  function automatic logic signed [SB-1:0] sat_s(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SMAX) begin
      c = SMAX;
    end else if (v < SMIN) begin
      c = SMIN;
    end
    return c[SB-1:0];
  endfunction

  // Configuration registers.
  logic [15:0] room_fb;
  logic [14:0] damp;
  logic [16:0] wet_d;
  logic [16:0] wet_c;
  logic [16:0] dry;
  logic [15:0] rate;
  logic        rescale_pend;

  // Sequencer and working registers.
  logic [4:0]              state;
  logic [LIW-1:0]          k;
  logic [AW-1:0]           caddr;
  logic [AW-1:0]           run;
  logic signed [SB-1:0]    x;
  logic signed [SB-1:0]    inp;
  logic signed [SB-1:0]    cout;
  logic signed [SB-1:0]    freg;
  logic signed [CW-1:0]    lsum;
  logic signed [CW-1:0]    rsum;
  logic signed [SB-1:0]    lres;
  logic signed [SB-1:0]    lp [LPN];

  // Shared unit and store connections.
  crv_pkg::mac_op_t        mop;
  logic signed [CW-1:0]    ma;
  logic signed [CF-1:0]    mb;
  logic signed [ACC_W-1:0] acc;
  crv_pkg::line_cmd_t      lcmd;
  logic [AW-1:0]           cur_addr;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [SB-1:0]    mem_wdata;
  logic signed [SB-1:0]    rd_q;

  // Derived values.
  logic [10:0]             tuning;
  logic signed [ACC_W-1:0] len_raw;
  logic [LW-1:0]           len_c;
  logic [AW+1:0]           run_s0;
  logic [AW+1:0]           run_s1;
  logic [AW+1:0]           run_s2;
  logic signed [SB-1:0]    comb_w;
  logic signed [CW-1:0]    ap_x;
  logic signed [SB-1:0]    ap_w;
  logic signed [CW-1:0]    ap_y;
  logic                    out_free;

  crv_mac #(.A_W(CW), .ACC_W(ACC_W)) u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mop),
    .a   (ma),
    .b   (mb),
    .acc (acc)
  );

  crv_dmem #(.DELAY_WORDS(DELAY_WORDS), .SAMPLE_BITS(SAMPLE_BITS)) u_dmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cur_addr),
    .rdata (rd_q)
  );

  crv_lines #(.DELAY_WORDS(DELAY_WORDS), .NUM_LINES(TL)) u_lines (
    .clk       (clk),
    .cmd       (lcmd),
    .idx       (k),
    .init_len  (len_c),
    .init_base (run),
    .cur_addr  (cur_addr)
  );

  // Line length from the tuning and rate scale, clamped to 1..65535, and the
  // next base taken modulo the store size.
  assign tuning  = crv_pkg::line_tuning(6'(k), 6'(2 * NC));
  assign len_raw = acc >>> 14;
  assign len_c   = (len_raw == '0) ? LW'(1) :
                   (len_raw > ACC_W'(65535)) ? LW'(65535) : len_raw[LW-1:0];
  assign run_s0  = {2'b00, run} + (AW+2)'(len_c);
  assign run_s1  = (run_s0 >= DWV) ? run_s0 - DWV : run_s0;
  assign run_s2  = (run_s1 >= DWV) ? run_s1 - DWV : run_s1;

  // Comb feedback write and allpass update.
  assign comb_w = sat_s(ACC_W'(inp) + rnd16(acc));
  assign ap_x   = k[0] ? rsum : lsum;
  assign ap_w   = sat_s(ACC_W'(ap_x) + ((ACC_W'(rd_q) + ACC_W'(1)) >>> 1));
  assign ap_y   = CW'(rd_q) - ap_x;

  assign in_stall = !(state == S_IDLE && !rescale_pend);
  assign out_free = !out_valid || !out_stall;

  // Operand selection and store writes for each sequencer step.
  always_comb begin
    mop       = '0;
    ma        = '0;
    mb        = '0;
    lcmd      = '0;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = '0;
    unique case (state) inside
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = caddr;
      end
      S_LEN_MUL: begin
        mop = '{valid: 1'b1, clear: 1'b1};
        ma  = CW'(tuning);
        mb  = $signed({2'b00, rate});
      end
      S_LEN_SET: begin
        lcmd.init = 1'b1;
      end
      S_IN_MUL: begin
        mop = '{valid: 1'b1, clear: 1'b1};
        ma  = CW'(x);
        mb  = crv_pkg::INPUT_GAIN;
      end
      S_C_M1: begin
        mop = '{valid: 1'b1, clear: 1'b1};
        ma  = CW'(rd_q);
        mb  = $signed({1'b0, 17'd65536 - {2'b00, damp}});
      end
      S_C_M2: begin
        mop = '{valid: 1'b1, clear: 1'b0};
        ma  = CW'(lp[k[LPW-1:0]]);
        mb  = $signed({3'b000, damp});
      end
      S_C_M3: begin
        mop = '{valid: 1'b1, clear: 1'b1};
        ma  = CW'(freg);
        mb  = $signed({2'b00, room_fb});
      end
      S_C_WR: begin
        mem_we    = 1'b1;
        mem_wdata = comb_w;
        lcmd.adv  = 1'b1;
      end
      S_A_WR: begin
        mem_we    = 1'b1;
        mem_wdata = ap_w;
        lcmd.adv  = 1'b1;
      end
      S_O_M1: begin
        mop = '{valid: 1'b1, clear: 1'b1};
        ma  = lsum;
        mb  = $signed({1'b0, wet_d});
      end
      S_O_M2: begin
        mop = '{valid: 1'b1, clear: 1'b0};
        ma  = rsum;
        mb  = $signed({1'b0, wet_c});
      end
      S_O_M3, S_O_M6: begin
        mop = '{valid: 1'b1, clear: 1'b0};
        ma  = CW'(x);
        mb  = $signed({1'b0, dry});
      end
      S_O_M4: begin
        mop = '{valid: 1'b1, clear: 1'b1};
        ma  = rsum;
        mb  = $signed({1'b0, wet_d});
      end
      S_O_M5: begin
        mop = '{valid: 1'b1, clear: 1'b0};
        ma  = lsum;
        mb  = $signed({1'b0, wet_c});
      end
      default: begin
      end
    endcase
  end

  // Configuration writes; a new rate scale asks for a length pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      room_fb      <= 16'd55050;
      damp         <= 15'd0;
      wet_d        <= 17'd21845;
      wet_c        <= 17'd0;
      dry          <= 17'd32768;
      rate         <= 16'd16384;
      rescale_pend <= 1'b0;
    end else begin
      if (state == S_IDLE && rescale_pend) begin
        rescale_pend <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROOM: room_fb <= cfg_data[15:0];
          REG_DAMP: damp    <= cfg_data[14:0];
          REG_WETD: wet_d   <= cfg_data;
          REG_WETC: wet_c   <= cfg_data;
          REG_DRY:  dry     <= cfg_data;
          REG_RATE: begin
            rate         <= cfg_data[15:0];
            rescale_pend <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      caddr <= '0;
      k     <= '0;
      run   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          caddr <= caddr + 1'b1;
          if (caddr == AW'(DELAY_WORDS - 1)) begin
            k     <= '0;
            run   <= '0;
            state <= S_LEN_MUL;
          end
        end
        S_LEN_MUL: state <= S_LEN_W1;
        S_LEN_W1:  state <= S_LEN_SET;
        S_LEN_SET: begin
          run <= run_s2[AW-1:0];
          if (k == LIW'(TL - 1)) begin
            state <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_LEN_MUL;
          end
        end
        S_IDLE: begin
          if (rescale_pend) begin
            k     <= '0;
            run   <= '0;
            state <= S_LEN_MUL;
          end else if (in_valid) begin
            state <= S_IN_MUL;
          end
        end
        S_IN_MUL: state <= S_IN_W1;
        S_IN_W1:  state <= S_IN_SET;
        S_IN_SET: begin
          k     <= '0;
          state <= S_C_RD;
        end
        S_C_RD: state <= S_C_M1;
        S_C_M1: state <= S_C_M2;
        S_C_M2: state <= S_C_W1;
        S_C_W1: state <= S_C_F;
        S_C_F:  state <= S_C_M3;
        S_C_M3: state <= S_C_W2;
        S_C_W2: state <= S_C_WR;
        S_C_WR: begin
          k     <= k + 1'b1;
          state <= (k == LIW'(2 * NC - 1)) ? S_A_RD : S_C_RD;
        end
        S_A_RD: state <= S_A_WR;
        S_A_WR: begin
          if (k == LIW'(TL - 1)) begin
            state <= S_O_M1;
          end else begin
            k     <= k + 1'b1;
            state <= S_A_RD;
          end
        end
        S_O_M1: state <= S_O_M2;
        S_O_M2: state <= S_O_M3;
        S_O_M3: state <= S_O_M4;
        S_O_M4: state <= S_O_M5;
        S_O_M5: state <= S_O_M6;
        S_O_M6: state <= S_O_W1;
        S_O_W1: state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sample path registers. The lowpass states are cleared entry by entry
  // during the first cycles of the store clearing pass.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR && caddr < AW'(LPN)) begin
      lp[caddr[LPW-1:0]] <= '0;
    end
    if (state == S_IDLE && !in_stall && in_valid) begin
      x <= in_sample;
    end
    if (state == S_IN_SET) begin
      inp  <= sat_s(rnd16(acc));
      lsum <= '0;
      rsum <= '0;
    end
    if (state == S_C_M1) begin
      cout <= rd_q;
    end
    if (state == S_C_F) begin
      freg             <= sat_s(rnd16(acc));
      lp[k[LPW-1:0]]   <= sat_s(rnd16(acc));
    end
    if (state == S_C_WR) begin
      if (k[0]) begin
        rsum <= rsum + CW'(cout);
      end else begin
        lsum <= lsum + CW'(cout);
      end
    end
    if (state == S_A_WR) begin
      if (k[0]) begin
        rsum <= ap_y;
      end else begin
        lsum <= ap_y;
      end
    end
    if (state == S_O_M5) begin
      lres <= sat_s(rnd16(acc));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_left  <= lres;
      out_right <= sat_s(rnd16(acc));
    end
  end

  // Checks on the sequencer.
  `CRV_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall,
    "sample accepted but the core took another at once")
  `CRV_ASSERT_HOLDS(a_comb_index, clk, rst, state == S_C_WR, k < LIW'(2 * NC),
    "comb write with an allpass line index")
  `CRV_ASSERT_HOLDS(a_ap_index, clk, rst, state == S_A_WR, k >= LIW'(2 * NC),
    "allpass write with a comb line index")

endmodule

`default_nettype wire
